/* sv/quad_mesh_edge_dedup_macros.svh */
// assertion macros for the quad mesh edge dedup block
`ifndef QUAD_MESH_EDGE_DEDUP_MACROS_SVH
`define QUAD_MESH_EDGE_DEDUP_MACROS_SVH

// same-cycle implication, checked outside reset
`define QMED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define QMED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/qmed_pkg.sv */
// shared types and constants of the quad mesh edge dedup block
`timescale 1ns / 1ps

package qmed_pkg;

    localparam int MAX_NODES    = 4096;
    localparam int MAX_ELEMENTS = 4096;
    localparam int MAX_EDGES    = 8192;
    localparam int HASH_SLOTS   = 16384;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int ELEM_W  = $clog2(MAX_ELEMENTS);
    localparam int EDGE_W  = $clog2(MAX_EDGES);
    localparam int IDX_W   = $clog2(HASH_SLOTS);
    localparam int CNT_W   = 13;
    localparam int MADE_W  = EDGE_W + 1;
    localparam int HSHIFT  = 7;
    localparam int PROD_W  = IDX_W + HSHIFT;
    localparam int KEY_W   = 2 * NODE_W;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    // corner pairs of the four sides
    localparam logic [3:0][1:0] SIDE_FROM = {2'd0, 2'd3, 2'd1, 2'd0};
    localparam logic [3:0][1:0] SIDE_TO   = {2'd3, 2'd2, 2'd2, 2'd1};

    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_ELEM_COUNT = 1'b1;

    typedef enum logic [2:0] {
        STAT_NEW    = 3'd0,
        STAT_MATCH  = 3'd1,
        STAT_THIRD  = 3'd2,
        STAT_FULL   = 3'd3,
        STAT_RANGE  = 3'd4,
        STAT_EXCESS = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_HASH,
        S_INDEX,
        S_READ,
        S_CHECK,
        S_OUT
    } t_state;

    // one hash table slot
    typedef struct packed {
        logic              used;
        logic              interior;
        logic [NODE_W-1:0] lo;
        logic [NODE_W-1:0] hi;
        logic [EDGE_W-1:0] id;
        logic              first_lo;
        logic [ELEM_W-1:0] elem;
        logic [1:0]        side;
    } t_slot;

    // table write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_slot            data;
    } t_wr_req;

endpackage

/* sv/qmed_hash.sv */
// registered multiplicative hash of an unordered node pair
`timescale 1ns / 1ps

module qmed_hash (
    input  logic                      i_clk,
    input  logic [qmed_pkg::NODE_W-1:0] i_lo,
    input  logic [qmed_pkg::NODE_W-1:0] i_hi,
    output logic [qmed_pkg::IDX_W-1:0]  o_idx
);
    import qmed_pkg::*;

    logic [KEY_W-1:0]    key;
    logic [2*PROD_W-1:0] prod_full;
    logic [PROD_W-1:0]   r_prod;

    // key is lo + MAX_NODES * hi, a plain concatenation
    assign key       = {i_hi, i_lo};
    // only the low product bits survive the shift and the slot mask
    assign prod_full = key[PROD_W-1:0] * HASH_MULT[PROD_W-1:0];

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full[PROD_W-1:0];
    end

    assign o_idx = r_prod[PROD_W-1:HSHIFT];

endmodule

/* sv/qmed_table.sv */
// hashed edge slot memory, one write and one registered read port
`timescale 1ns / 1ps

module qmed_table (
    input  logic                         i_clk,
    input  qmed_pkg::t_wr_req            i_wr,
    input  logic [qmed_pkg::IDX_W-1:0]   i_rd_addr,
    output qmed_pkg::t_slot              o_rd_data
);
    import qmed_pkg::*;

    t_slot mem [HASH_SLOTS];
    t_slot r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

/* sv/quad_mesh_edge_dedup.sv */
// Quad mesh edge dedup: one element word in, four side result words out, in side order
// 0..3. After reset a clearing pass over every slot empties the edge table; o_stall is
// high meanwhile. Each side passes through set-up, hash multiply, index, table read, check
// and output, with a further table read and check for each extra linear probe, all through
// one hash unit and one table port. An excess or out-of-range element gives its four
// flagged words in turn. A new element is taken only once the last word of the previous
// one is gone.
`timescale 1ns / 1ps
`include "quad_mesh_edge_dedup_macros.svh"

module quad_mesh_edge_dedup (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [11:0]                    i_corner_a,
    input  logic [11:0]                    i_corner_b,
    input  logic [11:0]                    i_corner_c,
    input  logic [11:0]                    i_corner_d,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_side_index,
    output logic [12:0]                    o_edge_number,
    output logic [2:0]                     o_status,
    output logic [11:0]                    o_neighbour_element,
    output logic [1:0]                     o_neighbour_side,
    output logic signed [1:0]              o_orientation,
    output logic                           o_last_side,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [12:0]                    i_cfg_data
);
    import qmed_pkg::*;

    t_state                  r_state, n_state;
    logic [1:0]              r_side, n_side;
    logic [3:0][NODE_W-1:0]  r_corner, n_corner;
    logic [NODE_W-1:0]       r_lo, n_lo, r_hi, n_hi, r_c0, n_c0;
    logic [IDX_W-1:0]        r_idx, n_idx, r_clr, n_clr;
    logic [MADE_W-1:0]       r_edges, n_edges;
    logic [CNT_W-1:0]        r_elem_cnt, n_elem_cnt;
    logic [CNT_W-1:0]        r_node_count, r_element_count;
    logic                    r_flagged, n_flagged;
    t_status                 r_o_status, n_o_status;
    logic [EDGE_W-1:0]       r_o_edge, n_o_edge;
    logic [ELEM_W-1:0]       r_o_nel, n_o_nel;
    logic [1:0]              r_o_nside, n_o_nside;
    logic [1:0]              r_o_orient, n_o_orient;

    logic [IDX_W-1:0]        hash_idx;
    t_slot                   rd_slot;
    t_wr_req                 wr;
    logic [NODE_W-1:0]       sc0, sc1;
    logic                    excess, bad, hit;
    logic [3:0][NODE_W-1:0]  in_corner;

    qmed_hash u_hash (
        .i_clk (i_clk),
        .i_lo  (r_lo),
        .i_hi  (r_hi),
        .o_idx (hash_idx)
    );

    qmed_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_slot)
    );

    // input word checks
    assign in_corner = {i_corner_d, i_corner_c, i_corner_b, i_corner_a};
    assign excess = (r_elem_cnt >= r_element_count) || (r_elem_cnt[CNT_W-1] == 1'b1);
    always_comb begin
        bad = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if ({1'b0, in_corner[k]} >= r_node_count) begin
                bad = 1'b1;
            end
        end
    end

    // side endpoints and slot compare
    assign sc0 = r_corner[SIDE_FROM[r_side]];
    assign sc1 = r_corner[SIDE_TO[r_side]];
    assign hit = rd_slot.used && (rd_slot.lo == r_lo) && (rd_slot.hi == r_hi);

    // sequencer next state and outputs
    always_comb begin
        n_state    = r_state;
        n_side     = r_side;
        n_corner   = r_corner;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_c0       = r_c0;
        n_idx      = r_idx;
        n_clr      = r_clr;
        n_edges    = r_edges;
        n_elem_cnt = r_elem_cnt;
        n_flagged  = r_flagged;
        n_o_status = r_o_status;
        n_o_edge   = r_o_edge;
        n_o_nel    = r_o_nel;
        n_o_nside  = r_o_nside;
        n_o_orient = r_o_orient;
        wr         = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr.en   = 1'b1;
                wr.addr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == IDX_W'(HASH_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_corner   = in_corner;
                    n_side     = 2'd0;
                    n_o_edge   = '0;
                    n_o_nel    = '0;
                    n_o_nside  = '0;
                    n_o_orient = '0;
                    if (excess) begin
                        n_flagged  = 1'b1;
                        n_o_status = STAT_EXCESS;
                        n_state    = S_OUT;
                    end else if (bad) begin
                        n_flagged  = 1'b1;
                        n_o_status = STAT_RANGE;
                        n_state    = S_OUT;
                    end else begin
                        n_flagged = 1'b0;
                        n_state   = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_c0    = sc0;
                n_lo    = (sc0 < sc1) ? sc0 : sc1;
                n_hi    = (sc0 < sc1) ? sc1 : sc0;
                n_state = S_HASH;
            end
            S_HASH: begin
                n_state = S_INDEX;
            end
            S_INDEX: begin
                n_idx   = hash_idx;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_o_edge   = '0;
                n_o_nel    = '0;
                n_o_nside  = '0;
                n_o_orient = '0;
                if (!rd_slot.used) begin
                    n_state = S_OUT;
                    if (r_edges >= MADE_W'(MAX_EDGES)) begin
                        n_o_status = STAT_FULL;
                    end else begin
                        wr.en            = 1'b1;
                        wr.addr          = r_idx;
                        wr.data.used     = 1'b1;
                        wr.data.interior = 1'b0;
                        wr.data.lo       = r_lo;
                        wr.data.hi       = r_hi;
                        wr.data.id       = r_edges[EDGE_W-1:0];
                        wr.data.first_lo = (r_c0 == r_lo);
                        wr.data.elem     = r_elem_cnt[ELEM_W-1:0];
                        wr.data.side     = r_side;
                        n_edges          = r_edges + 1'b1;
                        n_o_status       = STAT_NEW;
                        n_o_edge         = r_edges[EDGE_W-1:0];
                        n_o_orient       = 2'b01;
                    end
                end else if (hit) begin
                    // second meeting turns the edge interior, a third leaves it so
                    wr.en            = 1'b1;
                    wr.addr          = r_idx;
                    wr.data          = rd_slot;
                    wr.data.interior = 1'b1;
                    n_o_status = rd_slot.interior ? STAT_THIRD : STAT_MATCH;
                    n_o_edge   = rd_slot.id;
                    n_o_nel    = rd_slot.elem;
                    n_o_nside  = rd_slot.side;
                    n_o_orient = (r_c0 == (rd_slot.first_lo ? rd_slot.lo : rd_slot.hi))
                                 ? 2'b01 : 2'b11;
                    n_state    = S_OUT;
                end else begin
                    // linear probe, wraps with the index width
                    n_idx   = r_idx + 1'b1;
                    n_state = S_READ;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_side = r_side + 1'b1;
                    if (r_side == 2'd3) begin
                        if (r_o_status != STAT_EXCESS) begin
                            n_elem_cnt = r_elem_cnt + 1'b1;
                        end
                        n_state = S_IDLE;
                    end else if (!r_flagged) begin
                        n_state = S_SETUP;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr           <= '0;
            r_edges         <= '0;
            r_elem_cnt      <= '0;
            r_side          <= '0;
            r_flagged       <= 1'b0;
            r_node_count    <= CNT_W'(MAX_NODES);
            r_element_count <= CNT_W'(MAX_ELEMENTS);
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_edges    <= n_edges;
            r_elem_cnt <= n_elem_cnt;
            r_side     <= n_side;
            r_flagged  <= n_flagged;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_NODE_COUNT) begin
                    r_node_count <= i_cfg_data;
                end
                if (i_cfg_index == CFG_ELEM_COUNT) begin
                    r_element_count <= i_cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_corner   <= n_corner;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_c0       <= n_c0;
        r_idx      <= n_idx;
        r_o_status <= n_o_status;
        r_o_edge   <= n_o_edge;
        r_o_nel    <= n_o_nel;
        r_o_nside  <= n_o_nside;
        r_o_orient <= n_o_orient;
    end

    assign o_stall             = (r_state != S_IDLE);
    assign o_cfg_ready         = 1'b1;
    assign o_valid             = (r_state == S_OUT);
    assign o_side_index        = r_side;
    assign o_edge_number       = r_o_edge;
    assign o_status            = r_o_status;
    assign o_neighbour_element = r_o_nel;
    assign o_neighbour_side    = r_o_nside;
    assign o_orientation       = r_o_orient;
    assign o_last_side         = (r_side == 2'd3);

    // checks
    `QMED_ASSERT_NOW(a_out_blocks_in, o_valid, o_stall, "result word shown while input open")
    `QMED_ASSERT_NOW(a_edges_bound, 1'b1, r_edges <= MADE_W'(MAX_EDGES), "edge count overflow")
    `QMED_ASSERT_NEXT(a_last_frees, o_valid && !i_stall && o_last_side, !o_stall, "no idle after last word")
    `QMED_ASSERT_NOW(a_no_write_idle, r_state == S_IDLE, !wr.en, "table written while idle")

endmodule
